// ----- rtl/core/rrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrsp_pkg
// Types, codes and helpers shared by the reply stream parser modules.
// ----------------------------------------------------------------------------
package rrsp_pkg;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ELEM    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] TYPE_ERROR  = 3'd0;
    localparam logic [2:0] TYPE_STATUS = 3'd1;
    localparam logic [2:0] TYPE_INT    = 3'd2;
    localparam logic [2:0] TYPE_STRING = 3'd3;
    localparam logic [2:0] TYPE_ARRAY  = 3'd4;
    localparam logic [2:0] TYPE_NIL    = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
    localparam logic [2:0] ERR_NOT_BULK = 3'd2;
    localparam logic [2:0] ERR_MISMATCH = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG = 3'd4;

    typedef enum logic [10:0] {
        PH_TYPE      = 11'b000_0000_0001,
        PH_LINE      = 11'b000_0000_0010,
        PH_INT       = 11'b000_0000_0100,
        PH_BULK_HDR  = 11'b000_0000_1000,
        PH_BULK_DATA = 11'b000_0001_0000,
        PH_SKIP1     = 11'b000_0010_0000,
        PH_SKIP2     = 11'b000_0100_0000,
        PH_ARR_HDR   = 11'b000_1000_0000,
        PH_ELEM_TYPE = 11'b001_0000_0000,
        PH_ELEM_HDR  = 11'b010_0000_0000,
        PH_ELEM_DATA = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [63:0] accum;
        logic        negative;
        logic        bad;
        logic        stopped;
    } num_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [2:0]  rtype;
        logic        nil;
        logic [63:0] ival;
        logic [31:0] len;
        logic [31:0] idx;
        logic [2:0]  err;
        logic        rend;
        logic        last;
    } res_t;

    function automatic res_t make_res(
        input logic [1:0]  kind,
        input logic [7:0]  data,
        input logic [2:0]  rtype,
        input logic        nil,
        input logic [63:0] ival,
        input logic [31:0] len,
        input logic [31:0] idx,
        input logic [2:0]  err,
        input logic        rend
    );
        res_t r;
        r.kind  = kind;
        r.data  = data;
        r.rtype = rtype;
        r.nil   = nil;
        r.ival  = ival;
        r.len   = len;
        r.idx   = idx;
        r.err   = err;
        r.rend  = rend;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] num_value(input num_t n);
        logic [63:0] v;
        if (n.bad)
            v = '1;
        else if (n.negative)
            v = 64'd0 - n.accum;
        else
            v = n.accum;
        return v;
    endfunction

endpackage

// ----- rtl/core/rrsp_num.sv -----
// ----------------------------------------------------------------------------
// rrsp_num
// Decimal number accumulator: one content byte per call, sign, wrap, bad digit.
// ----------------------------------------------------------------------------
module rrsp_num (
    input  rrsp_pkg::num_t cur,
    input  logic [7:0]     ch,
    input  logic           first,
    output rrsp_pkg::num_t nxt
);

    always_comb
    begin
        nxt = cur;
        if (!cur.stopped)
        begin
            if (ch == rrsp_pkg::CH_CR)
            begin
                nxt.stopped = 1'b1;
            end
            else if (first && ch == rrsp_pkg::CH_MINUS)
            begin
                nxt.negative = 1'b1;
            end
            else if (first && ch == rrsp_pkg::CH_PLUS)
            begin
                nxt.negative = cur.negative;
            end
            else if (ch >= rrsp_pkg::CH_ZERO && ch <= rrsp_pkg::CH_NINE)
            begin
                // times ten, then add the digit
                nxt.accum = (cur.accum << 3) + (cur.accum << 1)
                            + {56'd0, ch - rrsp_pkg::CH_ZERO};
            end
            else
            begin
                nxt.bad     = 1'b1;
                nxt.stopped = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/resp_reply_stream_parser.sv -----
// ----------------------------------------------------------------------------
// resp_reply_stream_parser
// Parses a reply byte stream into payload, element, done and error transactions.
// ----------------------------------------------------------------------------
// A byte is held in the input register; its results are registered into the result buffer when it is processed.
// Throughput: one byte per cycle while res_stall is low; a byte that yields two results holds the
// input until the two-entry result buffer has drained one of them.
// Reset: asynchronous, active low; parser waits for a type byte, buffers empty.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         kind,
    output logic [7:0]         data,
    output logic [2:0]         reply_type,
    output logic               element_nil,
    output logic signed [63:0] integer_value,
    output logic [31:0]        length,
    output logic [31:0]        element_index,
    output logic [2:0]         error_code,
    output logic               reply_end,
    output logic               last_of_run
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] LEN_MASK = {LB{1'b1}};

    // input register
    logic       in_v_reg, in_v_next;
    logic [7:0] in_byte_reg;

    // parser state
    rrsp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       ctype_reg, ctype_next;
    logic             pend_reg, pend_next;
    rrsp_pkg::num_t   num_reg, num_next, num_fed;
    logic [LB-1:0]    cnt_reg, cnt_next;
    logic [LB-1:0]    exp_reg, exp_next;
    logic [LB-1:0]    tot_reg, tot_next;
    logic [LB-1:0]    elc_reg, elc_next;

    // result buffer
    rrsp_pkg::res_t res0_reg, res0_next, res1_reg, res1_next;
    logic [1:0]     rcnt_reg, rcnt_next;

    logic take, room, proc, accept;

    // step outputs
    rrsp_pkg::res_t r0, r1;
    logic [1:0]     nres;

    logic [1:0]     nc;
    logic [7:0]     c, c0, c1;
    logic           eol;
    logic [63:0]    v;
    logic           vneg, vbig;
    logic [31:0]    cnt32, exp32, tot32, elc32, pidx;
    logic [LB:0]    bulk_cnt;
    logic [LB-1:0]  elc_inc;

    assign take     = (rcnt_reg != 2'd0) && !res_stall;
    assign room     = (rcnt_reg == 2'd0) || (rcnt_reg == 2'd1 && take);
    assign proc     = in_v_reg && room;
    assign rx_stall = in_v_reg && !proc;
    assign accept   = rx_valid && !rx_stall;

    assign c     = in_byte_reg;
    assign v     = rrsp_pkg::num_value(num_reg);
    assign vneg  = v[63];
    assign vbig  = !vneg && (|v[63:LB]);
    assign cnt32 = 32'(64'(cnt_reg));
    assign exp32 = 32'(64'(exp_reg));
    assign tot32 = 32'(64'(tot_reg));
    assign elc32 = 32'(64'(elc_reg));
    assign pidx  = (ctype_reg == rrsp_pkg::TYPE_ARRAY) ? elc32 : 32'd0;
    assign bulk_cnt = {1'b0, cnt_reg} + {{LB{1'b0}}, 1'b1};
    assign elc_inc  = elc_reg + {{(LB-1){1'b0}}, 1'b1};

    rrsp_num u_num (
        .cur   (num_reg),
        .ch    (c0),
        .first (cnt_reg == '0),
        .nxt   (num_fed)
    );

    // split the byte into line content, honoring CR LF as the only line end
    always_comb
    begin
        nc        = 2'd0;
        c0        = c;
        c1        = c;
        eol       = 1'b0;
        pend_next = pend_reg;
        if (pend_reg)
        begin
            if (c == rrsp_pkg::CH_LF)
            begin
                pend_next = 1'b0;
                eol       = 1'b1;
            end
            else if (c == rrsp_pkg::CH_CR)
            begin
                nc = 2'd1;
                c0 = rrsp_pkg::CH_CR;
            end
            else
            begin
                pend_next = 1'b0;
                nc        = 2'd2;
                c0        = rrsp_pkg::CH_CR;
            end
        end
        else if (c == rrsp_pkg::CH_CR)
        begin
            pend_next = 1'b1;
        end
        else
        begin
            nc = 2'd1;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        ctype_next = ctype_reg;
        num_next   = num_reg;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        tot_next   = tot_reg;
        elc_next   = elc_reg;
        r0         = '0;
        r1         = '0;
        nres       = 2'd0;

        unique case (phase_reg)
            rrsp_pkg::PH_TYPE:
            begin
                num_next = '0;
                cnt_next = '0;
                case (c)
                    rrsp_pkg::CH_MINUS:
                    begin
                        ctype_next = rrsp_pkg::TYPE_ERROR;
                        phase_next = rrsp_pkg::PH_LINE;
                    end
                    rrsp_pkg::CH_PLUS:
                    begin
                        ctype_next = rrsp_pkg::TYPE_STATUS;
                        phase_next = rrsp_pkg::PH_LINE;
                    end
                    rrsp_pkg::CH_COLON:
                    begin
                        ctype_next = rrsp_pkg::TYPE_INT;
                        phase_next = rrsp_pkg::PH_INT;
                    end
                    rrsp_pkg::CH_DOLLAR:
                    begin
                        ctype_next = rrsp_pkg::TYPE_STRING;
                        phase_next = rrsp_pkg::PH_BULK_HDR;
                    end
                    rrsp_pkg::CH_STAR:
                    begin
                        ctype_next = rrsp_pkg::TYPE_ARRAY;
                        phase_next = rrsp_pkg::PH_ARR_HDR;
                    end
                    default:
                    begin
                        ctype_next = rrsp_pkg::TYPE_ERROR;
                        phase_next = rrsp_pkg::PH_TYPE;
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_ERROR, 8'd0,
                            rrsp_pkg::TYPE_ERROR, 1'b0, 64'd0, 32'd0, 32'd0,
                            rrsp_pkg::ERR_UNKNOWN, 1'b1);
                        nres = 2'd1;
                    end
                endcase
            end

            rrsp_pkg::PH_BULK_DATA:
            begin
                r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_PAYLOAD, c, ctype_reg,
                    1'b0, 64'd0, 32'd0, 32'd0, rrsp_pkg::ERR_NONE, 1'b0);
                nres     = 2'd1;
                cnt_next = bulk_cnt[LB-1:0];
                if (bulk_cnt >= {1'b0, exp_reg})
                    phase_next = rrsp_pkg::PH_SKIP1;
            end

            rrsp_pkg::PH_SKIP1:
            begin
                phase_next = rrsp_pkg::PH_SKIP2;
            end

            rrsp_pkg::PH_SKIP2:
            begin
                phase_next = rrsp_pkg::PH_TYPE;
                r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_DONE, 8'd0,
                    rrsp_pkg::TYPE_STRING, 1'b0, 64'd0, exp32, 32'd0,
                    rrsp_pkg::ERR_NONE, 1'b1);
                nres = 2'd1;
            end

            rrsp_pkg::PH_ELEM_TYPE:
            begin
                if (c == rrsp_pkg::CH_DOLLAR)
                begin
                    num_next   = '0;
                    cnt_next   = '0;
                    phase_next = rrsp_pkg::PH_ELEM_HDR;
                end
                else
                begin
                    phase_next = rrsp_pkg::PH_TYPE;
                    r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_ERROR, 8'd0, ctype_reg,
                        1'b0, 64'd0, 32'd0, 32'd0, rrsp_pkg::ERR_NOT_BULK, 1'b1);
                    nres = 2'd1;
                end
            end

            rrsp_pkg::PH_LINE, rrsp_pkg::PH_ELEM_DATA:
            begin
                if (nc != 2'd0)
                begin
                    if (cnt_reg == LEN_MASK)
                    begin
                        phase_next = rrsp_pkg::PH_TYPE;
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_ERROR, 8'd0,
                            ctype_reg, 1'b0, 64'd0, 32'd0, 32'd0,
                            rrsp_pkg::ERR_TOO_LONG, 1'b1);
                        nres = 2'd1;
                    end
                    else
                    begin
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_PAYLOAD, c0,
                            ctype_reg, 1'b0, 64'd0, 32'd0, pidx,
                            rrsp_pkg::ERR_NONE, 1'b0);
                        nres     = 2'd1;
                        cnt_next = cnt_reg + {{(LB-1){1'b0}}, 1'b1};
                        if (nc == 2'd2)
                        begin
                            nres = 2'd2;
                            if (cnt_next == LEN_MASK)
                            begin
                                phase_next = rrsp_pkg::PH_TYPE;
                                r1 = rrsp_pkg::make_res(rrsp_pkg::KIND_ERROR,
                                    8'd0, ctype_reg, 1'b0, 64'd0, 32'd0, 32'd0,
                                    rrsp_pkg::ERR_TOO_LONG, 1'b1);
                            end
                            else
                            begin
                                r1 = rrsp_pkg::make_res(rrsp_pkg::KIND_PAYLOAD,
                                    c1, ctype_reg, 1'b0, 64'd0, 32'd0, pidx,
                                    rrsp_pkg::ERR_NONE, 1'b0);
                                cnt_next = cnt_reg + {{(LB-2){1'b0}}, 2'd2};
                            end
                        end
                    end
                end
                else if (eol)
                begin
                    if (phase_reg == rrsp_pkg::PH_LINE)
                    begin
                        phase_next = rrsp_pkg::PH_TYPE;
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_DONE, 8'd0,
                            ctype_reg, 1'b0, 64'd0, cnt32, 32'd0,
                            rrsp_pkg::ERR_NONE, 1'b1);
                        nres = 2'd1;
                    end
                    else if (cnt_reg != exp_reg)
                    begin
                        phase_next = rrsp_pkg::PH_TYPE;
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_ERROR, 8'd0,
                            ctype_reg, 1'b0, 64'd0, 32'd0, 32'd0,
                            rrsp_pkg::ERR_MISMATCH, 1'b1);
                        nres = 2'd1;
                    end
                    else
                    begin
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_ELEM, 8'd0,
                            rrsp_pkg::TYPE_STRING, 1'b0, 64'd0, exp32, elc32,
                            rrsp_pkg::ERR_NONE, 1'b0);
                        nres     = 2'd1;
                        elc_next = elc_inc;
                        if (elc_inc >= tot_reg)
                        begin
                            phase_next = rrsp_pkg::PH_TYPE;
                            r1 = rrsp_pkg::make_res(rrsp_pkg::KIND_DONE, 8'd0,
                                rrsp_pkg::TYPE_ARRAY, 1'b0, 64'd0, tot32, 32'd0,
                                rrsp_pkg::ERR_NONE, 1'b1);
                            nres = 2'd2;
                        end
                        else
                        begin
                            phase_next = rrsp_pkg::PH_ELEM_TYPE;
                        end
                    end
                end
            end

            rrsp_pkg::PH_INT, rrsp_pkg::PH_BULK_HDR, rrsp_pkg::PH_ARR_HDR,
            rrsp_pkg::PH_ELEM_HDR:
            begin
                if (nc != 2'd0)
                begin
                    num_next = num_fed;
                    if (cnt_reg != LEN_MASK)
                        cnt_next = cnt_reg + {{(LB-1){1'b0}}, 1'b1};
                    if (nc == 2'd2 && cnt_next != LEN_MASK)
                        cnt_next = cnt_next + {{(LB-1){1'b0}}, 1'b1};
                end
                else if (eol)
                begin
                    if (phase_reg == rrsp_pkg::PH_INT)
                    begin
                        phase_next = rrsp_pkg::PH_TYPE;
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_DONE, 8'd0,
                            rrsp_pkg::TYPE_INT, 1'b0, v, 32'd0, 32'd0,
                            rrsp_pkg::ERR_NONE, 1'b1);
                        nres = 2'd1;
                    end
                    else if (vneg && phase_reg == rrsp_pkg::PH_ELEM_HDR)
                    begin
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_ELEM, 8'd0,
                            rrsp_pkg::TYPE_NIL, 1'b1, 64'd0, 32'd0, elc32,
                            rrsp_pkg::ERR_NONE, 1'b0);
                        nres     = 2'd1;
                        elc_next = elc_inc;
                        if (elc_inc >= tot_reg)
                        begin
                            phase_next = rrsp_pkg::PH_TYPE;
                            r1 = rrsp_pkg::make_res(rrsp_pkg::KIND_DONE, 8'd0,
                                rrsp_pkg::TYPE_ARRAY, 1'b0, 64'd0, tot32, 32'd0,
                                rrsp_pkg::ERR_NONE, 1'b1);
                            nres = 2'd2;
                        end
                        else
                        begin
                            phase_next = rrsp_pkg::PH_ELEM_TYPE;
                        end
                    end
                    else if (vneg)
                    begin
                        phase_next = rrsp_pkg::PH_TYPE;
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_DONE, 8'd0,
                            rrsp_pkg::TYPE_NIL, 1'b0, 64'd0, 32'd0, 32'd0,
                            rrsp_pkg::ERR_NONE, 1'b1);
                        nres = 2'd1;
                    end
                    else if (vbig)
                    begin
                        phase_next = rrsp_pkg::PH_TYPE;
                        r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_ERROR, 8'd0,
                            ctype_reg, 1'b0, 64'd0, 32'd0, 32'd0,
                            rrsp_pkg::ERR_TOO_LONG, 1'b1);
                        nres = 2'd1;
                    end
                    else if (phase_reg == rrsp_pkg::PH_BULK_HDR)
                    begin
                        exp_next   = v[LB-1:0];
                        cnt_next   = '0;
                        phase_next = (v == 64'd0) ? rrsp_pkg::PH_SKIP1
                                                  : rrsp_pkg::PH_BULK_DATA;
                    end
                    else if (phase_reg == rrsp_pkg::PH_ARR_HDR)
                    begin
                        if (v == 64'd0)
                        begin
                            phase_next = rrsp_pkg::PH_TYPE;
                            r0 = rrsp_pkg::make_res(rrsp_pkg::KIND_DONE, 8'd0,
                                rrsp_pkg::TYPE_ARRAY, 1'b0, 64'd0, 32'd0, 32'd0,
                                rrsp_pkg::ERR_NONE, 1'b1);
                            nres = 2'd1;
                        end
                        else
                        begin
                            tot_next   = v[LB-1:0];
                            elc_next   = '0;
                            phase_next = rrsp_pkg::PH_ELEM_TYPE;
                        end
                    end
                    else
                    begin
                        exp_next   = v[LB-1:0];
                        num_next   = '0;
                        cnt_next   = '0;
                        phase_next = rrsp_pkg::PH_ELEM_DATA;
                    end
                end
            end

            default:
            begin
                phase_next = rrsp_pkg::PH_TYPE;
            end
        endcase

        // mark the last result of this byte
        if (nres == 2'd1)
            r0.last = 1'b1;
        if (nres == 2'd2)
            r1.last = 1'b1;
    end

    always_comb
    begin
        in_v_next = in_v_reg;
        if (accept)
            in_v_next = 1'b1;
        else if (proc)
            in_v_next = 1'b0;

        res0_next = res0_reg;
        res1_next = res1_reg;
        rcnt_next = rcnt_reg;
        if (proc)
        begin
            res0_next = r0;
            res1_next = r1;
            rcnt_next = nres;
        end
        else if (take)
        begin
            // advance the second result to the head
            res0_next = res1_reg;
            rcnt_next = rcnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            rcnt_reg  <= 2'd0;
            phase_reg <= rrsp_pkg::PH_TYPE;
            ctype_reg <= '0;
            pend_reg  <= 1'b0;
            num_reg   <= '0;
            cnt_reg   <= '0;
            exp_reg   <= '0;
            tot_reg   <= '0;
            elc_reg   <= '0;
        end
        else
        begin
            in_v_reg <= in_v_next;
            rcnt_reg <= rcnt_next;
            if (proc)
            begin
                phase_reg <= phase_next;
                ctype_reg <= ctype_next;
                // an error, a finished line or a change of phase clears the held CR
                pend_reg  <= (phase_next == rrsp_pkg::PH_TYPE
                              || phase_reg == rrsp_pkg::PH_TYPE
                              || phase_reg == rrsp_pkg::PH_ELEM_TYPE) ? 1'b0
                             : pend_next && (phase_reg == phase_next);
                num_reg   <= num_next;
                cnt_reg   <= cnt_next;
                exp_reg   <= exp_next;
                tot_reg   <= tot_next;
                elc_reg   <= elc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= rx_byte;
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign res_valid     = (rcnt_reg != 2'd0);
    assign kind          = res0_reg.kind;
    assign data          = res0_reg.data;
    assign reply_type    = res0_reg.rtype;
    assign element_nil   = res0_reg.nil;
    assign integer_value = res0_reg.ival;
    assign length        = res0_reg.len;
    assign element_index = res0_reg.idx;
    assign error_code    = res0_reg.err;
    assign reply_end     = res0_reg.rend;
    assign last_of_run   = res0_reg.last;

endmodule
